[rtl/core/cddc_pkg.sv]
`default_nettype none

package cddc_pkg;

  // Stream payload widths
  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  localparam int DAYS_W = 22;

  localparam logic [DAYS_W-1:0] MAX_DAY_NUMBER = 22'd2932896;
  localparam logic [DAYS_W-1:0] EPOCH_SHIFT    = 22'd719468;

  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [17:0] DAYS_PER_CENT = 18'd36524;
  localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;

  // Reciprocals for the constant divisions: floor(x / d) = (x * M) >> k
  localparam logic [22:0] RCP_ERA  = 23'd7525902; // 1/146097, k = 40
  localparam logic [22:0] RCP_1460 = 23'd367720;  // 1/1460,   k = 29
  localparam logic [22:0] RCP_365  = 23'd367720;  // 1/365,    k = 27
  localparam logic [22:0] RCP_153  = 23'd3427;    // 1/153,    k = 19
  localparam logic [22:0] RCP_100  = 23'd5243;    // 1/100,    k = 19
  localparam logic [22:0] RCP_7    = 23'd4793491; // 1/7,      k = 25
  localparam logic [22:0] DAYS_PER_YEAR = 23'd365;
  localparam logic [22:0] ERA_MUL       = 23'd146097;

  localparam logic [15:0] YEAR_MIN = 16'd1970;
  localparam logic [15:0] YEAR_MAX = 16'd9999;

  // Operation codes
  localparam logic [1:0] OP_LOAD_CIVIL = 2'd0;
  localparam logic [1:0] OP_LOAD_DAYS  = 2'd1;
  localparam logic [1:0] OP_ADD_OFFSET = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_CIVIL    = 2'd1;
  localparam logic [1:0] ERR_RANGE    = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // First day of each month in a March-based year
  function automatic logic [8:0] first_doy(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:  d = 9'd0;
      4'd1:  d = 9'd31;
      4'd2:  d = 9'd61;
      4'd3:  d = 9'd92;
      4'd4:  d = 9'd122;
      4'd5:  d = 9'd153;
      4'd6:  d = 9'd184;
      4'd7:  d = 9'd214;
      4'd8:  d = 9'd245;
      4'd9:  d = 9'd275;
      4'd10: d = 9'd306;
      4'd11: d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/core/civil_date_day_counter.sv]
// Civil date day counter.
// Keeps a day number counted from 1970-01-01. Each transfer on the s_axis
// channel carries one operation in s_axis_tuser: load a civil date, load a
// raw day number, or add a signed offset. Each operation yields exactly one
// transfer on m_axis: the stored day number, its date, weekday and an error
// code in m_axis_tuser.
// The result is registered after the steps of the state machine: ST_OP, then
// ST_F1 to ST_F3 for a civil date load, then ST_R0 to ST_R9. The input is ready
// again in the cycle after the result is registered, so the block takes no new
// item before the last one is through. The steps are set by the single shared
// 22x23 multiplier, which does most constant divisions by reciprocal, one product per step.
// The result sits in its own output register: while the receiver stalls the
// block still takes and works on the next item, and holds it in its final
// step until the previous result has been transferred.
// Reset (rst, synchronous) clears the stored day number to 1970-01-01 and
// drops m_axis_tvalid; s_axis_tready rises in the first cycle after reset.
`default_nettype none

module civil_date_day_counter (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // day_of_month[7:0], month_in[15:8], year_in[31:16], day_count_in[53:32],
  // day_offset[76:54], zero pad[79:77]
  input  wire  [cddc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // operation[1:0]
  input  wire  [cddc_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // day_number[21:0], day_out[26:22], month_out[30:27], year_out[44:31],
  // weekday[47:45]
  output logic [cddc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // error_code[1:0]
  output logic [cddc_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

  import cddc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_OP   = 4'd1;
  localparam logic [3:0] ST_F1   = 4'd2;
  localparam logic [3:0] ST_F2   = 4'd3;
  localparam logic [3:0] ST_F3   = 4'd4;
  localparam logic [3:0] ST_R0   = 4'd5;
  localparam logic [3:0] ST_R1   = 4'd6;
  localparam logic [3:0] ST_R2   = 4'd7;
  localparam logic [3:0] ST_R3   = 4'd8;
  localparam logic [3:0] ST_R4   = 4'd9;
  localparam logic [3:0] ST_R5   = 4'd10;
  localparam logic [3:0] ST_R6   = 4'd11;
  localparam logic [3:0] ST_R7   = 4'd12;
  localparam logic [3:0] ST_R8   = 4'd13;
  localparam logic [3:0] ST_R9   = 4'd14;

  logic [3:0]        state;
  logic [DAYS_W-1:0] stored;

  // latched input item
  logic [1:0]  op;
  logic [7:0]  dom;
  logic [7:0]  mon;
  logic [15:0] year;
  logic [21:0] cnt;
  logic [22:0] off;

  // shared multiplier
  logic [21:0] mul_a;
  logic [22:0] mul_b;
  logic        mul_en;
  logic [44:0] prod;

  // working registers
  logic        leap;
  logic [6:0]  qyy;
  logic [1:0]  err;
  logic [4:0]  era;
  logic [17:0] doe;
  logic [17:0] tsum;
  logic [8:0]  yoe;
  logic [8:0]  doy;
  logic [2:0]  wday;

  // output register
  logic [21:0] days_o;
  logic [4:0]  day_o;
  logic [3:0]  month_o;
  logic [13:0] year_o;
  logic [2:0]  wday_o;
  logic [1:0]  err_o;

  // derived values
  logic        m_le2;
  logic [15:0] yy;
  logic [3:0]  mi;
  logic [9:0]  qy;
  logic [16:0] hund;
  logic        leap_next;
  logic [4:0]  last_day;
  logic        civil_ok;
  logic [23:0] n_full;
  logic signed [23:0] sum;
  logic        sum_bad;
  logic [21:0] z;
  logic [21:0] wx;
  logic [2:0]  cents;
  logic [17:0] tsum_next;
  logic [1:0]  yoe_cents;
  logic [17:0] doy_full;
  logic [3:0]  mp;
  logic [3:0]  mm;
  logic [13:0] era400;
  logic        out_free;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign m_le2 = (mon <= 8'd2);
  assign yy    = year - {15'd0, m_le2};
  assign mi    = (mon > 8'd2) ? (mon[3:0] - 4'd3) : (mon[3:0] + 4'd9);

  // leap year from year / 100 (product of the first civil step)
  assign qy   = prod[28:19];
  assign hund = {1'b0, qy, 6'd0} + {2'b0, qy, 5'd0} + {5'd0, qy, 2'd0};
  assign leap_next = ((year[1:0] == 2'd0) && ({1'b0, year} != hund)) ||
                     (({1'b0, year} == hund) && (qy[1:0] == 2'd0));

  assign last_day = ((mon == 8'd2) && leap) ? 5'd29 : month_len(mon[3:0]);
  assign civil_ok = (year >= YEAR_MIN) && (year <= YEAR_MAX) &&
                    (mon >= 8'd1) && (mon <= 8'd12) &&
                    (dom >= 8'd1) && (dom <= {3'd0, last_day});

  // 365*yy + yy/4 - yy/100 + yy/400 + doy - epoch
  assign n_full = {2'd0, prod[21:0]} + {12'd0, yy[13:2]} + {19'd0, qyy[6:2]}
                + {15'd0, first_doy(mi)} + {16'd0, dom} - {17'd0, qyy}
                - 24'd1 - {2'd0, EPOCH_SHIFT};

  assign sum = $signed({2'b00, stored}) + $signed({off[22], off});
  assign sum_bad = sum[23] || (sum[22:0] > {1'b0, MAX_DAY_NUMBER});

  assign z  = stored + EPOCH_SHIFT;
  assign wx = stored + 22'd4;

  // doe/36524 and doe/146096 by compare
  assign cents = {2'd0, doe >= DAYS_PER_CENT} + {2'd0, doe >= 18'(2 * DAYS_PER_CENT)}
               + {2'd0, doe >= 18'(3 * DAYS_PER_CENT)} + {2'd0, doe >= ERA_LAST_DAY};
  assign tsum_next = doe - {11'd0, prod[35:29]} + {15'd0, cents}
                   - {17'd0, doe == ERA_LAST_DAY};

  assign yoe_cents = {1'b0, yoe >= 9'd100} + {1'b0, yoe >= 9'd200}
                   + {1'b0, yoe >= 9'd300};
  assign doy_full = doe - (prod[17:0] + {11'd0, yoe[8:2]} - {16'd0, yoe_cents});

  assign mp = prod[22:19];
  assign mm = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
  assign era400 = {1'b0, era, 8'd0} + {2'b0, era, 7'd0} + {5'd0, era, 4'd0};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state)
      ST_OP: begin
        mul_a  = {6'd0, year};
        mul_b  = RCP_100;
        mul_en = 1'b1;
      end
      ST_F1: begin
        mul_a  = {8'd0, yy[13:0]};
        mul_b  = RCP_100;
        mul_en = 1'b1;
      end
      ST_F2: begin
        mul_a  = {8'd0, yy[13:0]};
        mul_b  = DAYS_PER_YEAR;
        mul_en = 1'b1;
      end
      ST_R0: begin
        mul_a  = z;
        mul_b  = RCP_ERA;
        mul_en = 1'b1;
      end
      ST_R1: begin
        mul_a  = {17'd0, prod[44:40]};
        mul_b  = ERA_MUL;
        mul_en = 1'b1;
      end
      ST_R2: begin
        mul_a  = wx;
        mul_b  = RCP_7;
        mul_en = 1'b1;
      end
      ST_R3: begin
        mul_a  = {4'd0, doe};
        mul_b  = RCP_1460;
        mul_en = 1'b1;
      end
      ST_R5: begin
        mul_a  = {4'd0, tsum};
        mul_b  = RCP_365;
        mul_en = 1'b1;
      end
      ST_R6: begin
        mul_a  = {13'd0, prod[35:27]};
        mul_b  = DAYS_PER_YEAR;
        mul_en = 1'b1;
      end
      ST_R8: begin
        mul_a  = {11'd0, {doy, 2'd0} + {2'd0, doy} + 11'd2};
        mul_b  = RCP_153;
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= {23'd0, mul_a} * {22'd0, mul_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      stored        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // in the final step a free output register is reloaded below
      if (m_axis_tvalid && m_axis_tready && (state != ST_R9)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= s_axis_tuser[1:0];
            dom   <= s_axis_tdata[7:0];
            mon   <= s_axis_tdata[15:8];
            year  <= s_axis_tdata[31:16];
            cnt   <= s_axis_tdata[53:32];
            off   <= s_axis_tdata[76:54];
            state <= ST_OP;
          end
        end
        ST_OP: begin
          case (op)
            OP_LOAD_CIVIL: begin
              err   <= ERR_OK;
              state <= ST_F1;
            end
            OP_LOAD_DAYS: begin
              state <= ST_R0;
              if (cnt > MAX_DAY_NUMBER) begin
                err <= ERR_RANGE;
              end else begin
                err    <= ERR_OK;
                stored <= cnt;
              end
            end
            OP_ADD_OFFSET: begin
              state <= ST_R0;
              if (sum_bad) begin
                err <= ERR_OVERFLOW;
              end else begin
                err    <= ERR_OK;
                stored <= sum[21:0];
              end
            end
            default: begin
              err   <= ERR_OK;
              state <= ST_R0;
            end
          endcase
        end
        ST_F1: begin
          leap  <= leap_next;
          state <= ST_F2;
        end
        ST_F2: begin
          qyy   <= prod[25:19];
          state <= ST_F3;
        end
        ST_F3: begin
          if (!civil_ok) begin
            err <= ERR_CIVIL;
          end else if (n_full > {2'd0, MAX_DAY_NUMBER}) begin
            err <= ERR_RANGE;
          end else begin
            stored <= n_full[21:0];
          end
          state <= ST_R0;
        end
        ST_R0: begin
          state <= ST_R1;
        end
        ST_R1: begin
          era   <= prod[44:40];
          state <= ST_R2;
        end
        ST_R2: begin
          doe   <= 18'(z - prod[21:0]);
          state <= ST_R3;
        end
        ST_R3: begin
          // x - 7q == x + q (mod 8), and the remainder is below 7
          wday  <= wx[2:0] + prod[27:25];
          state <= ST_R4;
        end
        ST_R4: begin
          tsum  <= tsum_next;
          state <= ST_R5;
        end
        ST_R5: begin
          state <= ST_R6;
        end
        ST_R6: begin
          yoe   <= prod[35:27];
          state <= ST_R7;
        end
        ST_R7: begin
          doy   <= doy_full[8:0];
          state <= ST_R8;
        end
        ST_R8: begin
          state <= ST_R9;
        end
        ST_R9: begin
          if (out_free) begin
            days_o        <= stored;
            day_o         <= 5'(doy - first_doy(mp) + 9'd1);
            month_o       <= mm;
            year_o        <= {5'd0, yoe} + era400 + {13'd0, mm <= 4'd2};
            wday_o        <= wday;
            err_o         <= err;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {wday_o, year_o, month_o, day_o, days_o};
  assign m_axis_tuser = err_o;

`ifndef ASSERT_OFF
  a_stored_max: assert property (@(posedge clk) disable iff (rst)
    stored <= MAX_DAY_NUMBER)
    else $error("stored day number above maximum");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  a_out_date: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (month_o >= 4'd1) && (month_o <= 4'd12) &&
                      (day_o >= 5'd1) && (wday_o <= 3'd6) &&
                      (year_o >= 14'd1970) && (year_o <= 14'd9999))
    else $error("result date out of range");
`endif

endmodule

`default_nettype wire
